[hw/rtl/sbe_pkg.sv]
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types and constants for the Sobel edge binariser.
// ----------------------------------------------------------------------------
package sbe_pkg;

   // Longest input row the line store can hold
   localparam int MAX_WIDTH = 1024;
   localparam int COL_W     = $clog2(MAX_WIDTH);

   // Register field widths
   localparam int THR_W     = 8;
   localparam int FWIDTH_W  = 11;
   localparam int FHEIGHT_W = 12;
   localparam int CSR_W     = 12;
   localparam int CSR_IDX_W = 2;

   // Width for comparing a column against the clamped row width
   localparam int LIM_W = (COL_W + 1 > FWIDTH_W) ? COL_W + 1 : FWIDTH_W;

   // Pixel and line store word
   localparam int PIX_W  = 8;
   localparam int LINE_W = 2 * PIX_W;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_WIDTH     = 2'd1,
      CSR_HEIGHT    = 2'd2
   } csr_index_type;

   // Position of one request within the frame
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic             produce;
      logic             last;
   } pos_type;

endpackage

[hw/rtl/sbe_scan.sv]
// ----------------------------------------------------------------------------
// sbe_scan
// Raster position counters: column and row of each request, frame wrap.
// ----------------------------------------------------------------------------
module sbe_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic                          frame_start,
   input  logic [sbe_pkg::FWIDTH_W-1:0]  frame_width,
   input  logic [sbe_pkg::FHEIGHT_W-1:0] frame_height,
   output sbe_pkg::pos_type              pos
);

   logic [sbe_pkg::COL_W-1:0]     col_ff, col_in, col_cur;
   logic [sbe_pkg::FHEIGHT_W-1:0] row_ff, row_in, row_cur;
   logic [sbe_pkg::LIM_W-1:0]     fw_ext, w_eff;
   logic [sbe_pkg::FHEIGHT_W-1:0] h_eff;
   logic                          end_row, end_frame;

   // Clamp the row width to 3..MAX_WIDTH and the height to at least 3
   always_comb begin
      fw_ext = sbe_pkg::LIM_W'(frame_width);
      if (fw_ext < sbe_pkg::LIM_W'(3)) begin
         w_eff = sbe_pkg::LIM_W'(3);
      end else if (fw_ext > sbe_pkg::LIM_W'(sbe_pkg::MAX_WIDTH)) begin
         w_eff = sbe_pkg::LIM_W'(sbe_pkg::MAX_WIDTH);
      end else begin
         w_eff = fw_ext;
      end
      h_eff = (frame_height < sbe_pkg::FHEIGHT_W'(3)) ? sbe_pkg::FHEIGHT_W'(3) : frame_height;
   end

   // Current position, a frame start restarts at the origin
   always_comb begin
      col_cur   = frame_start ? '0 : col_ff;
      row_cur   = frame_start ? '0 : row_ff;
      end_row   = sbe_pkg::LIM_W'(col_cur) >= (w_eff - sbe_pkg::LIM_W'(1));
      end_frame = end_row && (row_cur >= (h_eff - sbe_pkg::FHEIGHT_W'(1)));

      pos.col     = col_cur;
      pos.produce = (row_cur >= sbe_pkg::FHEIGHT_W'(2)) && (col_cur >= sbe_pkg::COL_W'(2));
      pos.last    = end_frame;
   end

   // Next position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (end_row) begin
            col_in = '0;
            row_in = end_frame ? '0 : row_cur + sbe_pkg::FHEIGHT_W'(1);
         end else begin
            col_in = col_cur + sbe_pkg::COL_W'(1);
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

[hw/rtl/sbe_line_store.sv]
// ----------------------------------------------------------------------------
// sbe_line_store
// Two previous rows held as one word per column, registered read with a
// bypass for a read of the column being written in the same cycle.
// ----------------------------------------------------------------------------
module sbe_line_store (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         rd_en,
   input  logic [sbe_pkg::COL_W-1:0]    rd_addr,
   input  logic                         wr_en,
   input  logic [sbe_pkg::COL_W-1:0]    wr_addr,
   input  logic [sbe_pkg::LINE_W-1:0]   wr_data,
   output logic [sbe_pkg::LINE_W-1:0]   rd_data
);

   // [15:8] two rows up, [7:0] one row up
   logic [sbe_pkg::LINE_W-1:0] mem [sbe_pkg::MAX_WIDTH];
   logic [sbe_pkg::LINE_W-1:0] rd_ff;
   logic [sbe_pkg::LINE_W-1:0] byp_data_ff;
   logic                       byp_ff, byp_in;

   assign byp_in = rd_en ? (wr_en && (wr_addr == rd_addr)) : byp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff       <= mem[rd_addr];
         byp_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else begin
         byp_ff <= byp_in;
      end
   end

   assign rd_data = byp_ff ? byp_data_ff : rd_ff;

endmodule

[hw/rtl/sbe_kernel.sv]
// ----------------------------------------------------------------------------
// sbe_kernel
// 3x3 window, Sobel sums in both directions and the threshold compare.
// ----------------------------------------------------------------------------
module sbe_kernel (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic [sbe_pkg::PIX_W-1:0]   pixel,
   input  logic [sbe_pkg::LINE_W-1:0]  line_word,
   input  logic [sbe_pkg::THR_W-1:0]   threshold,
   output logic                        edge_x,
   output logic                        edge_y
);

   // win_ff[row][col], row 0 oldest, col 2 newest
   logic [sbe_pkg::PIX_W-1:0] win_ff [3][3];
   logic [sbe_pkg::PIX_W-1:0] nw     [3][3];
   logic [9:0]  xp, xn, yp, yn;
   logic [10:0] gx, gy;
   logic [9:0]  ax, ay;

   // Window after the shift that this request causes
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         nw[r][0] = win_ff[r][1];
         nw[r][1] = win_ff[r][2];
      end
      nw[0][2] = line_word[15:8];
      nw[1][2] = line_word[7:0];
      nw[2][2] = pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else if (advance) begin
         win_ff <= nw;
      end
   end

   // Weighted column and row sums, 0..1020 each
   always_comb begin
      xp = {2'b00, nw[0][2]} + {1'b0, nw[1][2], 1'b0} + {2'b00, nw[2][2]};
      xn = {2'b00, nw[0][0]} + {1'b0, nw[1][0], 1'b0} + {2'b00, nw[2][0]};
      yp = {2'b00, nw[2][0]} + {1'b0, nw[2][1], 1'b0} + {2'b00, nw[2][2]};
      yn = {2'b00, nw[0][0]} + {1'b0, nw[0][1], 1'b0} + {2'b00, nw[0][2]};
      gx = {1'b0, xp} - {1'b0, xn};
      gy = {1'b0, yp} - {1'b0, yn};
   end

   // Magnitude and strict compare
   always_comb begin
      ax = gx[10] ? 10'(-gx) : gx[9:0];
      ay = gy[10] ? 10'(-gy) : gy[9:0];
      edge_x = ax > {2'b00, threshold};
      edge_y = ay > {2'b00, threshold};
   end

endmodule

[hw/rtl/sobel_edge_binarize.sv]
// ----------------------------------------------------------------------------
// sobel_edge_binarize
// Streaming 3x3 Sobel edge detector with a binary threshold. Grey pixels
// arrive in raster order, one request per clock while not stalled; every
// interior pixel gives one response carrying a horizontal and a vertical edge
// bit (set when the absolute Sobel sum is strictly above the threshold
// register) and a flag on the last response of the frame, so the result frame is (width-2) x (height-2).
// Sustained rate is one pixel per clock while the response side does not stall.
// A pixel's response is offered from the output register: the accepting edge
// registers the pixel and its line store read in stage 1, and the edge on
// which stage 1 moves on registers the window, sums and compare in the
// output register. Backpressure on a held response stalls the request side
// in the same cycle while stage 1 is occupied. The line store needs no
// clearing after reset. Width is clamped to 3..1024, height to at least 3.
// ----------------------------------------------------------------------------
module sobel_edge_binarize (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sbe_pkg::PIX_W-1:0]   req_pixel,
   input  logic                        req_frame_start,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_edge_x,
   output logic                        rsp_edge_y,
   output logic                        rsp_frame_last,
   // register writes
   input  logic                        csr_we,
   input  logic [sbe_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sbe_pkg::CSR_W-1:0]   csr_wdata
);

   logic [sbe_pkg::THR_W-1:0]     thr_ff;
   logic [sbe_pkg::FWIDTH_W-1:0]  fwidth_ff;
   logic [sbe_pkg::FHEIGHT_W-1:0] fheight_ff;

   logic                          req_accept;
   sbe_pkg::pos_type              pos;

   logic                          s1_valid_ff, s1_valid_in;
   logic [sbe_pkg::PIX_W-1:0]     s1_pixel_ff;
   sbe_pkg::pos_type              s1_pos_ff;
   logic                          s1_advance;

   logic [sbe_pkg::LINE_W-1:0]    line_word;
   logic                          kx, ky;

   logic                          out_free;
   logic                          out_valid_ff, out_valid_in;
   logic                          out_x_ff, out_y_ff, out_last_ff;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff     <= '0;
         fwidth_ff  <= sbe_pkg::FWIDTH_W'(640);
         fheight_ff <= sbe_pkg::FHEIGHT_W'(480);
      end else if (csr_we) begin
         unique case (csr_index)
            sbe_pkg::CSR_THRESHOLD: thr_ff     <= csr_wdata[sbe_pkg::THR_W-1:0];
            sbe_pkg::CSR_WIDTH:     fwidth_ff  <= csr_wdata[sbe_pkg::FWIDTH_W-1:0];
            sbe_pkg::CSR_HEIGHT:    fheight_ff <= csr_wdata[sbe_pkg::FHEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Handshake: stage 1 moves on whenever the output register is free
   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   sbe_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .frame_start  (req_frame_start),
      .frame_width  (fwidth_ff),
      .frame_height (fheight_ff),
      .pos          (pos)
   );

   // Line store: read at acceptance, write back when stage 1 moves on
   sbe_line_store u_line (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_accept),
      .rd_addr (pos.col),
      .wr_en   (s1_advance),
      .wr_addr (s1_pos_ff.col),
      .wr_data ({line_word[7:0], s1_pixel_ff}),
      .rd_data (line_word)
   );

   // Stage 1 register
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pixel_ff <= req_pixel;
         s1_pos_ff   <= pos;
      end
   end

   sbe_kernel u_kernel (
      .clock     (clock),
      .reset     (reset),
      .advance   (s1_advance),
      .pixel     (s1_pixel_ff),
      .line_word (line_word),
      .threshold (thr_ff),
      .edge_x    (kx),
      .edge_y    (ky)
   );

   // Output register, border pixels give no response
   assign out_valid_in = (s1_advance && s1_pos_ff.produce) || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance && s1_pos_ff.produce) begin
         out_x_ff    <= kx;
         out_y_ff    <= ky;
         out_last_ff <= s1_pos_ff.last;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_edge_x     = out_x_ff;
   assign rsp_edge_y     = out_y_ff;
   assign rsp_frame_last = out_last_ff;

endmodule

[hw/rtl/sbe_checker.sv]
// ----------------------------------------------------------------------------
// sbe_checker
// Port-level checks on the edge binariser, bound to the top level.
// ----------------------------------------------------------------------------
module sbe_checker (
   input logic clock,
   input logic reset,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_edge_x,
   input logic rsp_edge_y,
   input logic rsp_frame_last
);

   // A held response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // A held response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable({rsp_edge_x, rsp_edge_y, rsp_frame_last}))
      else $error("response payload changed while stalled");

   // Nothing is offered and nothing is held straight after reset
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   // Requests are only held back by backpressure on the response side
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled without response backpressure");

endmodule

bind sobel_edge_binarize sbe_checker u_sbe_checker (.*);
